// ----- design/dpvs_pkg.sv -----
// Package for the decimal place-value splitter.
// Widths, power-of-ten table, status types and FSM states; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpvs_pkg;

  localparam int unsigned ValueBitsDefault = 64;
  localparam int unsigned ValueW           = 64;
  localparam int unsigned AddendW          = 64;
  localparam int unsigned DigitW           = 4;
  localparam int unsigned PlaceW           = 5;
  localparam int unsigned MaxPlaces        = 20;

  // decimal digits of 2**bits - 1
  function automatic int unsigned num_places(input int unsigned bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  function automatic logic [AddendW-1:0] pow_ten(input logic [PlaceW-1:0] place);
    logic [AddendW-1:0] p;
    case (place)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } emit_state_e;

endpackage

`default_nettype wire

// ----- design/dpvs_if.sv -----
// Request and result channel interfaces of the place-value splitter.
// Depends on dpvs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dpvs_in_if import dpvs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface dpvs_out_if import dpvs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [AddendW-1:0] addend;
  logic [DigitW-1:0]  digit;
  logic [PlaceW-1:0]  place;
  logic               none;
  logic               last;

  modport source (output valid, output addend, output digit, output place,
                  output none, output last, input ready);
  modport sink   (input valid, input addend, input digit, input place,
                  input none, input last, output ready);
endinterface

`default_nettype wire

// ----- design/dpvs_conv.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on dpvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpvs_conv import dpvs_pkg::*; #(
  parameter  int unsigned ValueBits = ValueBitsDefault,
  localparam int unsigned NumPlaces = num_places(ValueBits),
  localparam int unsigned BcdW      = NumPlaces * DigitW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [ValueBits-1:0] value_i,
  output logic      [BcdW-1:0]      bcd_o,
  output conv_stat_t                stat_o
);

  localparam int unsigned CntW = $clog2(ValueBits + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [ValueBits-1:0] sh_q, sh_d;
  logic [BcdW-1:0]      bcd_q, bcd_d;
  logic [BcdW-1:0]      adj;

  always_comb begin
    for (int i = 0; i < NumPlaces; i++) begin
      adj[i*DigitW +: DigitW] = (bcd_q[i*DigitW +: DigitW] >= 4'd5)
                              ? bcd_q[i*DigitW +: DigitW] + 4'd3
                              : bcd_q[i*DigitW +: DigitW];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(ValueBits);
      sh_d   = value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      sh_d   = sh_q << 1;
      bcd_d  = {adj[BcdW-2:0], sh_q[ValueBits-1]};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o       = bcd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ----- design/dpvs_emit.sv -----
// Digit scanner: walks the BCD word one digit per cycle from the top place, held at a nonzero digit while rsp_o
// stalls, and registers one result per nonzero digit (one none result if all zero). Depends on dpvs_pkg, dpvs_if.
`timescale 1ns / 1ps
`default_nettype none

module dpvs_emit import dpvs_pkg::*; #(
  parameter  int unsigned NumPlaces = num_places(ValueBitsDefault),
  localparam int unsigned BcdW      = NumPlaces * DigitW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire logic [BcdW-1:0] bcd_i,
  output logic                 busy_o,
  dpvs_out_if.source           rsp_o
);

  emit_state_e state_q, state_d;

  logic [BcdW-1:0]           scan_q;
  logic [PlaceW-1:0]         place_q;
  logic                      ovalid_q, ovalid_d;
  logic [AddendW-1:0]        addend_q;
  logic [DigitW-1:0]         digit_q;
  logic [PlaceW-1:0]         oplace_q;
  logic                      none_q;
  logic                      last_q;

  logic [DigitW-1:0]         top_dig;
  logic                      rest_zero;
  logic                      all_zero;
  logic                      can_load;
  logic                      emit_en;
  logic                      shift_en;
  logic [AddendW+DigitW-1:0] prod;

  assign top_dig   = scan_q[BcdW-1 -: DigitW];
  assign rest_zero = (scan_q[BcdW-DigitW-1:0] == '0);
  assign all_zero  = rest_zero && (top_dig == '0);
  assign can_load  = !ovalid_q || rsp_o.ready;
  assign prod      = pow_ten(place_q) * top_dig;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (can_load && (all_zero || (top_dig != '0 && rest_zero))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_en  = 1'b0;
    shift_en = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_SCAN: begin
        emit_en  = can_load && (all_zero || top_dig != '0);
        shift_en = !all_zero && (top_dig == '0 || can_load);
      end
      default: ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (emit_en) ovalid_d = 1'b1;
    else if (rsp_o.ready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      scan_q  <= bcd_i;
      place_q <= PlaceW'(NumPlaces - 1);
    end else if (shift_en) begin
      scan_q  <= scan_q << DigitW;
      place_q <= place_q - 1'b1;
    end
    if (emit_en) begin
      addend_q <= all_zero ? '0 : prod[AddendW-1:0];
      digit_q  <= top_dig;
      oplace_q <= all_zero ? '0 : place_q;
      none_q   <= all_zero;
      last_q   <= rest_zero;
    end
  end

  assign busy_o       = (state_q == ST_SCAN);
  assign rsp_o.valid  = ovalid_q;
  assign rsp_o.addend = addend_q;
  assign rsp_o.digit  = digit_q;
  assign rsp_o.place  = oplace_q;
  assign rsp_o.none   = none_q;
  assign rsp_o.last   = last_q;

endmodule

`default_nettype wire

// ----- design/decimal_place_value_split_top.sv -----
// Decimal place-value splitter, top level.
// Usage:
//   req_i carries one unsigned value per request (valid/ready). Only the low
//   ValueBits bits take part. rsp_o returns, most significant place first,
//   one result per nonzero decimal digit: digit, place, addend = digit*10^place,
//   with last set on the final one. A zero value gives one result with none
//   and last set and the other fields zero.
// Timing:
//   After a request is taken, the shift-and-add-3 converter shifts in its
//   ValueBits bits, one bit per cycle, then the scanner visits one decimal
//   place per cycle from the top (up to num_places(ValueBits) places, 20
//   for 64 bits), stopping after the last nonzero digit. One request is in
//   flight at a time; the next is taken as soon as the scanner finishes,
//   even while the final result still sits in the output register.
//   A stalled receiver holds the scanner at the next nonzero digit; zero
//   digits are skipped regardless. Reset clears all control state and drops
//   rsp_o.valid.
// Depends on dpvs_pkg, dpvs_if, dpvs_conv, dpvs_emit.
`timescale 1ns / 1ps
`default_nettype none

module decimal_place_value_split_top import dpvs_pkg::*; #(
  parameter int unsigned ValueBits = ValueBitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dpvs_in_if.sink    req_i,
  dpvs_out_if.source rsp_o
);

  localparam int unsigned NumPlaces = num_places(ValueBits);
  localparam int unsigned BcdW      = NumPlaces * DigitW;

  conv_stat_t      conv_stat;
  logic            emit_busy;
  logic            accept;
  logic [BcdW-1:0] bcd;

  assign req_i.ready = !conv_stat.busy && !conv_stat.done && !emit_busy;
  assign accept      = req_i.valid && req_i.ready;

  dpvs_conv #(
    .ValueBits (ValueBits)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (req_i.value[ValueBits-1:0]),
    .bcd_o   (bcd),
    .stat_o  (conv_stat)
  );

  dpvs_emit #(
    .NumPlaces (NumPlaces)
  ) u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (conv_stat.done),
    .bcd_i  (bcd),
    .busy_o (emit_busy),
    .rsp_o  (rsp_o)
  );

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_stat.done |-> !emit_busy)
    else $error("scanner loaded while busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> conv_stat.busy)
    else $error("request taken but converter idle");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(conv_stat.busy && emit_busy))
    else $error("converter and scanner both busy");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.none) |-> (rsp_o.last && rsp_o.digit == '0))
    else $error("none result malformed");

  a_digit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.none) |-> (rsp_o.digit != '0 && rsp_o.digit <= 4'd9))
    else $error("bad digit on result");
`endif

endmodule

`default_nettype wire
